@@ rtl/mfg_pkg.sv @@
// package for the rating error gradient accumulator
// types, sizes and mode codes shared by the core and its multiplier unit
package mfg_pkg;
    localparam int NUM_USERS = 256;
    localparam int NUM_ITEMS = 256;
    localparam int MAX_DIM   = 16;
    localparam int UW = $clog2(NUM_USERS);
    localparam int IW = $clog2(NUM_ITEMS);
    localparam int DW = $clog2(MAX_DIM);
    localparam int FUA = UW + DW;
    localparam int FIA = IW + DW;

    localparam logic [3:0] MODE_WR_UF = 4'd0;
    localparam logic [3:0] MODE_WR_IF = 4'd1;
    localparam logic [3:0] MODE_WR_UB = 4'd2;
    localparam logic [3:0] MODE_WR_IB = 4'd3;
    localparam logic [3:0] MODE_RATE  = 4'd4;
    localparam logic [3:0] MODE_RD_UF = 4'd5;
    localparam logic [3:0] MODE_RD_IF = 4'd6;
    localparam logic [3:0] MODE_RD_UB = 4'd7;
    localparam logic [3:0] MODE_RD_IB = 4'd8;

    localparam logic CFG_MEAN = 1'b0;
    localparam logic CFG_DIM  = 1'b1;

    localparam logic signed [63:0] ACC_MAX = 64'sd140737488355327;
    localparam logic signed [63:0] ACC_MIN = -64'sd140737488355328;

    // saturate a 64-bit value to 48 bits
    function automatic logic signed [47:0] sat48(input logic signed [63:0] x);
        logic signed [63:0] r;
        begin
            r = x;
            if (x > ACC_MAX) r = ACC_MAX;
            else if (x < ACC_MIN) r = ACC_MIN;
            sat48 = r[47:0];
        end
    endfunction
endpackage

@@ rtl/mfg_mul.sv @@
// registered 32x32 signed multiplier with floor shift by 16
// depends on mfg_pkg
module mfg_mul (
    input  logic               clk,
    input  logic signed [31:0] a,
    input  logic signed [31:0] b,
    output logic signed [47:0] p
);
    import mfg_pkg::*;
    logic signed [63:0] prod;

    // arithmetic shift is floor division by 65536
    assign prod = a * b;
    always_ff @(posedge clk)
    begin
        p <= prod[63:16];
    end
endmodule

@@ rtl/mf_rating_error_gradient_accumulate_core.sv @@
// top level of the rating error gradient accumulator
// depends on mfg_pkg and mfg_mul
//
// Usage: the input channel (valid/ready) carries one command per transfer: factor or
// bias write, rating sample, or gradient read-and-clear. Every command yields one
// result transfer on the output channel (valid/ready). The config channel writes
// mean_rating (index 0) and dim_in_use (index 1); the user must do so only while
// nothing is in work, which the block does not enforce. A rating walks the dimensions
// in use one element at a time through the one shared multiplier and the one-port
// factor and gradient stores: in the dot pass each is addressed, its operands enter and
// its product is added; in the gradient pass each is addressed, its operands enter,
// then the user and item gradients are updated. One command is in work at a time; the
// next input transfer can come once the result is loaded. A stalled receiver holds its
// result in the output register while one more command is taken and worked; that
// command then waits for the register and in_ready stays low. Reset clears the control
// and output registers, sets dim_in_use to 16, then a clearing pass zeroes the gradient
// stores with in_ready low. Factor and bias stores are undefined until written.
module mf_rating_error_gradient_accumulate_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [3:0]          mode,
    input  logic [7:0]          user,
    input  logic [7:0]          item,
    input  logic [3:0]          dim_index,
    input  logic signed [31:0]  value,
    input  logic                last_in_batch,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                error_valid,
    output logic signed [31:0]  rating_error,
    output logic signed [47:0]  grad_value,
    output logic                batch_done,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_index,
    input  logic [31:0]         cfg_data
);
    import mfg_pkg::*;

    localparam int CW = (FUA > FIA) ? FUA : FIA;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_DOT  = 3'd2;
    localparam logic [2:0] S_ERR  = 3'd3;
    localparam logic [2:0] S_GRD  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;
    localparam logic [2:0] S_CLR  = 3'd6;

    logic [2:0] state_reg;
    logic [CW-1:0] clr_reg;
    logic signed [31:0] mean_reg;
    logic [4:0] dim_reg;
    logic [3:0] mode_reg;
    logic [UW-1:0] u_reg;
    logic [IW-1:0] i_reg;
    logic [DW-1:0] d_reg;
    logic signed [31:0] val_reg;
    logic last_reg;
    logic [4:0] k_reg;
    logic [1:0] ph_reg;
    logic signed [63:0] acc_reg;
    logic signed [31:0] err_reg;
    logic signed [47:0] grad_reg;
    logic [4:0] n_lim;
    logic out_load;
    logic signed [63:0] err_full;

    // memories
    logic signed [31:0] uf_mem [NUM_USERS*MAX_DIM];
    logic signed [31:0] if_mem [NUM_ITEMS*MAX_DIM];
    logic signed [31:0] ub_mem [NUM_USERS];
    logic signed [31:0] ib_mem [NUM_ITEMS];
    logic signed [47:0] ufg_mem [NUM_USERS*MAX_DIM];
    logic signed [47:0] ifg_mem [NUM_ITEMS*MAX_DIM];
    logic signed [47:0] ubg_mem [NUM_USERS];
    logic signed [47:0] ibg_mem [NUM_ITEMS];

    logic signed [31:0] uf_q, if_q, ub_q, ib_q;
    logic signed [47:0] ufg_q, ifg_q, ubg_q, ibg_q;
    logic [DW-1:0] kd;
    logic signed [31:0] ma, mb;
    logic signed [47:0] mp;
    logic [DW-1:0] ra_d;
    logic [UW-1:0] ra_u;
    logic [IW-1:0] ra_i;

    assign n_lim = (dim_reg > 5'(MAX_DIM)) ? 5'(MAX_DIM) : dim_reg;
    assign kd = k_reg[DW-1:0];
    assign in_ready = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_load = (state_reg == S_OUT) && (!out_valid || out_ready);

    // residual before saturation, biases are already folded into the sum
    assign err_full = (64'(val_reg) - 64'(mean_reg)) - acc_reg;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mean_reg <= '0;
            dim_reg <= 5'd16;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_MEAN: mean_reg <= cfg_data;
                CFG_DIM:  dim_reg <= cfg_data[4:0];
            endcase
        end
    end

    // shared multiplier: dot pass uses uf*if, gradient pass err*if then err*uf
    assign ma = (state_reg == S_DOT) ? uf_q : err_reg;
    assign mb = (state_reg == S_DOT || ph_reg == 2'd1) ? if_q : uf_q;
    mfg_mul u_mul (.clk(clk), .a(ma), .b(mb), .p(mp));

    // read ports, addressed by the element counter or the command
    assign ra_d = (state_reg == S_IDLE) ? dim_index[DW-1:0] :
                  (state_reg == S_RD) ? d_reg : kd;
    assign ra_u = (state_reg == S_IDLE) ? user[UW-1:0] : u_reg;
    assign ra_i = (state_reg == S_IDLE) ? item[IW-1:0] : i_reg;

    always_ff @(posedge clk)
    begin
        uf_q <= uf_mem[{ra_u, ra_d}];
        if_q <= if_mem[{ra_i, ra_d}];
        ub_q <= ub_mem[ra_u];
        ib_q <= ib_mem[ra_i];
        ufg_q <= ufg_mem[{ra_u, ra_d}];
        ifg_q <= ifg_mem[{ra_i, ra_d}];
        ubg_q <= ubg_mem[ra_u];
        ibg_q <= ibg_mem[ra_i];
    end

    // factor and bias stores
    always_ff @(posedge clk)
    begin
        if (state_reg == S_RD)
        begin
            if (mode_reg == MODE_WR_UF) uf_mem[{u_reg, d_reg}] <= val_reg;
            if (mode_reg == MODE_WR_IF) if_mem[{i_reg, d_reg}] <= val_reg;
            if (mode_reg == MODE_WR_UB) ub_mem[u_reg] <= val_reg;
            if (mode_reg == MODE_WR_IB) ib_mem[i_reg] <= val_reg;
        end
    end

    // gradient stores: clearing pass, read-and-clear, accumulate
    always_ff @(posedge clk)
    begin
        if (state_reg == S_CLR)
        begin
            ufg_mem[clr_reg[FUA-1:0]] <= '0;
            ifg_mem[clr_reg[FIA-1:0]] <= '0;
            ubg_mem[clr_reg[UW-1:0]] <= '0;
            ibg_mem[clr_reg[IW-1:0]] <= '0;
        end
        else if (state_reg == S_RD)
        begin
            if (mode_reg == MODE_RD_UF) ufg_mem[{u_reg, d_reg}] <= '0;
            if (mode_reg == MODE_RD_IF) ifg_mem[{i_reg, d_reg}] <= '0;
            if (mode_reg == MODE_RD_UB) ubg_mem[u_reg] <= '0;
            if (mode_reg == MODE_RD_IB) ibg_mem[i_reg] <= '0;
        end
        else if (state_reg == S_GRD && ph_reg == 2'd2)
            ufg_mem[{u_reg, kd}] <= sat48(64'(ufg_q) + 64'(mp));
        else if (state_reg == S_GRD && ph_reg == 2'd3)
            ifg_mem[{i_reg, kd}] <= sat48(64'(ifg_q) + 64'(mp));
        else if (out_load && mode_reg == MODE_RATE)
        begin
            ubg_mem[u_reg] <= sat48(64'(ubg_q) + 64'(err_reg));
            ibg_mem[i_reg] <= sat48(64'(ibg_q) + 64'(err_reg));
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            clr_reg <= '0;
            mode_reg <= '0;
            u_reg <= '0;
            i_reg <= '0;
            d_reg <= '0;
            val_reg <= '0;
            last_reg <= 1'b0;
            k_reg <= '0;
            ph_reg <= '0;
            acc_reg <= '0;
            err_reg <= '0;
            grad_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_CLR:
                begin
                    clr_reg <= clr_reg + CW'(1);
                    if (clr_reg == {CW{1'b1}}) state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        mode_reg <= mode;
                        u_reg <= user[UW-1:0];
                        i_reg <= item[IW-1:0];
                        d_reg <= dim_index[DW-1:0];
                        val_reg <= value;
                        last_reg <= last_in_batch;
                        k_reg <= '0;
                        ph_reg <= '0;
                        grad_reg <= '0;
                        state_reg <= S_RD;
                    end
                end
                S_RD:
                begin
                    // read data for the command address is now valid
                    if (mode_reg == MODE_RATE)
                    begin
                        acc_reg <= 64'(ub_q) + 64'(ib_q);
                        state_reg <= (n_lim == 5'd0) ? S_ERR : S_DOT;
                    end
                    else state_reg <= S_OUT;
                    unique case (mode_reg)
                        MODE_RD_UF: grad_reg <= ufg_q;
                        MODE_RD_IF: grad_reg <= ifg_q;
                        MODE_RD_UB: grad_reg <= ubg_q;
                        MODE_RD_IB: grad_reg <= ibg_q;
                        default: ;
                    endcase
                end
                S_DOT:
                begin
                    // ph 0: address k, ph 1: operands in, ph 2: product ready
                    unique case (ph_reg)
                        2'd0: ph_reg <= 2'd1;
                        2'd1: ph_reg <= 2'd2;
                        2'd2:
                        begin
                            acc_reg <= acc_reg + 64'(mp);
                            ph_reg <= 2'd0;
                            if (k_reg + 5'd1 >= n_lim)
                            begin
                                k_reg <= '0;
                                state_reg <= S_ERR;
                            end
                            else k_reg <= k_reg + 5'd1;
                        end
                        default: ph_reg <= 2'd0;
                    endcase
                end
                S_ERR:
                begin
                    if (err_full > 64'sd2147483647) err_reg <= 32'sh7fffffff;
                    else if (err_full < -64'sd2147483648) err_reg <= 32'sh80000000;
                    else err_reg <= err_full[31:0];
                    ph_reg <= 2'd0;
                    k_reg <= '0;
                    state_reg <= (n_lim == 5'd0) ? S_OUT : S_GRD;
                end
                S_GRD:
                begin
                    // ph 0 addr, ph 1 ops, ph 2 user grad product, ph 3 item grad
                    unique case (ph_reg)
                        2'd0: ph_reg <= 2'd1;
                        2'd1: ph_reg <= 2'd2;
                        2'd2: ph_reg <= 2'd3;
                        2'd3:
                        begin
                            ph_reg <= 2'd0;
                            if (k_reg + 5'd1 >= n_lim)
                            begin
                                k_reg <= '0;
                                state_reg <= S_OUT;
                            end
                            else k_reg <= k_reg + 5'd1;
                        end
                    endcase
                end
                S_OUT:
                begin
                    if (out_load) state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // output register, loaded once the previous transfer has gone
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
            error_valid <= 1'b0;
            rating_error <= '0;
            grad_value <= '0;
            batch_done <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid <= 1'b1;
            error_valid <= (mode_reg == MODE_RATE);
            rating_error <= (mode_reg == MODE_RATE) ? err_reg : 32'sd0;
            grad_value <= grad_reg;
            batch_done <= last_reg;
        end
        else if (out_ready) out_valid <= 1'b0;
    end

`ifndef ASSERT_OFF
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ready) else $error("ready while busy");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(error_valid)
        && $stable(rating_error) && $stable(grad_value) && $stable(batch_done)))
        else $error("result changed while stalled");
    a_k: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_GRD || state_reg == S_DOT) |-> (k_reg < n_lim))
        else $error("index past dims");
`endif
endmodule
